### rtl/touch_event_decoder_macros.svh
// Assertion helpers used by the decoder controller
`ifndef TOUCH_EVENT_DECODER_MACROS_SVH
`define TOUCH_EVENT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ted_pkg.sv
package ted_pkg;

    // Event types
    localparam logic [15:0] EV_SYN = 16'h0000;
    localparam logic [15:0] EV_KEY = 16'h0001;
    localparam logic [15:0] EV_ABS = 16'h0003;

    // Event codes
    localparam logic [15:0] ABS_X          = 16'h0000;
    localparam logic [15:0] ABS_Y          = 16'h0001;
    localparam logic [15:0] ABS_FORCE      = 16'h0018;
    localparam logic [15:0] ABS_MT_X       = 16'h0035;
    localparam logic [15:0] ABS_MT_Y       = 16'h0036;
    localparam logic [15:0] ABS_MT_TRACKID = 16'h0039;
    localparam logic [15:0] KEY_CONTACT    = 16'h014A;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H  = 3'd5;

    // Reset values of the configuration registers
    localparam logic signed [31:0] RST_RAW_MIN  = 32'sd0;
    localparam logic signed [31:0] RST_RAW_MAX  = 32'sd32767;
    localparam logic [15:0]        RST_SCREEN_W = 16'd1024;
    localparam logic [15:0]        RST_SCREEN_H = 16'd600;

    // Divider: one quotient bit per step
    localparam int QUO_W  = 16;
    localparam int PROD_W = 48;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MOVE    = 2'd2
    } t_action;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input request
        logic emit;      // load result register, commit touched flag
        logic prep;      // offset and range
        logic mul;       // product and saturation flags
        logic div_step;  // one restoring division step
        logic wb;        // write scaled coordinate
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_coord;
        logic act_valid;
    } t_dp_status;

endpackage

### rtl/ted_datapath.sv
module ted_datapath import ted_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [15:0]           i_event_type,
    input  logic [15:0]           i_event_code,
    input  logic signed [31:0]    i_event_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [1:0]            o_action,
    output logic [15:0]           o_pos_x,
    output logic [15:0]           o_pos_y
);

    // Configuration
    logic signed [31:0] r_raw_x_min, r_raw_x_max, r_raw_y_min, r_raw_y_max;
    logic [15:0]        r_screen_w, r_screen_h;

    // Captured request
    logic [15:0]        r_type, r_code;
    logic signed [31:0] r_value;

    // Architectural state
    logic        r_touched;
    logic [15:0] r_last_x, r_last_y;

    // Scaling pipeline
    logic signed [32:0] r_diff;
    logic [31:0]        r_range;
    logic [15:0]        r_screen;
    logic               r_sat_zero, r_sat_max;
    logic [PROD_W-1:0]  r_rem, r_div;
    logic [QUO_W-1:0]   r_quo;

    // Result register payload
    t_action     r_out_action;
    logic [15:0] r_out_x, r_out_y;

    // Decode
    logic    dec_x, dec_y, prs_req, rel_req, syn_req;
    logic    act_valid;
    t_action act;

    // Scaling combinational terms
    logic signed [31:0] sel_lo, sel_hi;
    logic [15:0]        sel_screen;
    logic signed [32:0] n_diff, n_range_full;
    logic [31:0]        n_range;
    logic [PROD_W-1:0]  n_prod;
    logic               rem_ge;
    logic [15:0]        n_coord;

    // Classify captured event
    always_comb begin
        dec_x   = 1'b0;
        dec_y   = 1'b0;
        prs_req = 1'b0;
        rel_req = 1'b0;
        syn_req = 1'b0;
        if (r_type == EV_ABS) begin
            if (r_code == ABS_X || r_code == ABS_MT_X) begin
                dec_x = 1'b1;
            end else if (r_code == ABS_Y || r_code == ABS_MT_Y) begin
                dec_y = 1'b1;
            end else if (r_code == ABS_MT_TRACKID) begin
                prs_req = !r_value[31];
                rel_req = r_value[31];
            end else if (r_code == ABS_FORCE) begin
                prs_req = !r_value[31] && (r_value != 32'sd0);
                rel_req = (r_value == 32'sd0);
            end
        end else if (r_type == EV_KEY) begin
            if (r_code == KEY_CONTACT) begin
                prs_req = (r_value == 32'sd1);
                rel_req = (r_value == 32'sd0);
            end
        end else if (r_type == EV_SYN) begin
            syn_req = 1'b1;
        end
    end

    // Action from request and touched flag
    always_comb begin
        act_valid = 1'b1;
        act       = ACT_MOVE;
        if (prs_req && !r_touched) begin
            act = ACT_PRESS;
        end else if (rel_req && r_touched) begin
            act = ACT_RELEASE;
        end else if (syn_req && r_touched) begin
            act = ACT_MOVE;
        end else begin
            act_valid = 1'b0;
        end
    end

    assign o_status.is_coord  = dec_x || dec_y;
    assign o_status.act_valid = act_valid;

    // Offset and range for the selected axis; non-positive range counts as 1
    assign sel_lo       = dec_y ? r_raw_y_min : r_raw_x_min;
    assign sel_hi       = dec_y ? r_raw_y_max : r_raw_x_max;
    assign sel_screen   = dec_y ? r_screen_h  : r_screen_w;
    assign n_diff       = {r_value[31], r_value} - {sel_lo[31], sel_lo};
    assign n_range_full = {sel_hi[31], sel_hi} - {sel_lo[31], sel_lo};
    assign n_range      = (!n_range_full[32] && (n_range_full != 33'sd0))
                          ? n_range_full[31:0] : 32'd1;

    // Product only matters when 0 <= diff < range, so 32x16 unsigned
    assign n_prod = PROD_W'(r_diff[31:0]) * PROD_W'(r_screen);
    assign rem_ge = (r_rem >= r_div);

    // Clamp and select final coordinate
    always_comb begin
        if (r_sat_zero) begin
            n_coord = 16'd0;
        end else if (r_sat_max) begin
            n_coord = r_screen - 16'd1;
        end else begin
            n_coord = r_quo;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_x_min <= RST_RAW_MIN;
            r_raw_x_max <= RST_RAW_MAX;
            r_raw_y_min <= RST_RAW_MIN;
            r_raw_y_max <= RST_RAW_MAX;
            r_screen_w  <= RST_SCREEN_W;
            r_screen_h  <= RST_SCREEN_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAW_X_MIN: r_raw_x_min <= i_cfg_data;
                CFG_RAW_X_MAX: r_raw_x_max <= i_cfg_data;
                CFG_RAW_Y_MIN: r_raw_y_min <= i_cfg_data;
                CFG_RAW_Y_MAX: r_raw_y_max <= i_cfg_data;
                CFG_SCREEN_W:  r_screen_w  <= i_cfg_data[15:0];
                CFG_SCREEN_H:  r_screen_h  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Touched flag and last coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched <= 1'b0;
            r_last_x  <= 16'd0;
            r_last_y  <= 16'd0;
        end else begin
            if (i_cmd.emit) begin
                if (act == ACT_PRESS) begin
                    r_touched <= 1'b1;
                end else if (act == ACT_RELEASE) begin
                    r_touched <= 1'b0;
                end
            end
            if (i_cmd.wb) begin
                if (dec_y) begin
                    r_last_y <= n_coord;
                end else begin
                    r_last_x <= n_coord;
                end
            end
        end
    end

    // Request capture, scaling pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_event_type;
            r_code  <= i_event_code;
            r_value <= i_event_value;
        end
        if (i_cmd.prep) begin
            r_diff   <= n_diff;
            r_range  <= n_range;
            r_screen <= sel_screen;
        end
        if (i_cmd.mul) begin
            r_sat_zero <= r_diff[32] || (r_screen == 16'd0);
            r_sat_max  <= !r_diff[32] && (r_diff[31:0] >= r_range);
            r_rem      <= n_prod;
            r_div      <= {1'b0, r_range, {(QUO_W-1){1'b0}}};
            r_quo      <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            r_div <= r_div >> 1;
        end
        if (i_cmd.emit) begin
            r_out_action <= act;
            r_out_x      <= r_last_x;
            r_out_y      <= r_last_y;
        end
    end

    assign o_action = r_out_action;
    assign o_pos_x  = r_out_x;
    assign o_pos_y  = r_out_y;

endmodule

### rtl/ted_ctrl.sv
`include "touch_event_decoder_macros.svh"

module ted_ctrl import ted_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_WB
    } t_state;

    localparam int STEP_W = $clog2(QUO_W);

    t_state                  r_state;
    logic [STEP_W-1:0]       r_step;
    logic                    r_out_valid;

    logic slot_free;
    logic emit_ok;

    assign slot_free = !r_out_valid || i_ready;
    assign emit_ok   = (r_state == S_DECODE) && i_status.act_valid && slot_free;

    // Commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.emit     = emit_ok;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.wb       = (r_state == S_WB);
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // Sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (i_status.is_coord) begin
                        r_state <= S_PREP;
                    end else if (!i_status.act_valid || slot_free) begin
                        // no action, or action delivered into result register
                        r_state <= S_IDLE;
                    end
                end
                S_PREP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TED_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_valid && o_ready,
        r_state == S_DECODE, "accepted request did not move to decode")
    `TED_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit,
        !r_out_valid || i_ready, "result overwritten before it was taken")
    `TED_ASSERT_NEXT(a_div_length, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_step == STEP_W'(QUO_W - 1)),
        r_state == S_WB, "divider did not finish after its last step")
    `TED_ASSERT_IMP(a_wb_coord_only, i_clk, i_rst_n, o_cmd.wb,
        i_status.is_coord && !o_cmd.emit, "coordinate write for a non-coordinate request")

endmodule

### rtl/touch_event_decoder.sv
// Touch, key and sync requests that give an action load the result register from decode;
// coordinate requests pass decode, offset, multiply, 16 divider steps and write, and update
// last X/Y only. A new request is accepted only after the previous one has returned to idle.
// A waiting result holds an action request in decode; coordinate requests never wait for it.
// Reset (synchronous, active low) clears touched, last X/Y and result valid, and loads the
// default ranges 0..32767 and screen size 1024x600.
module touch_event_decoder import ted_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_event_type,
    input  logic [15:0]           i_event_code,
    input  logic signed [31:0]    i_event_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_action,
    output logic [15:0]           o_pos_x,
    output logic [15:0]           o_pos_y
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer
    ted_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Decode, scaling and result payload
    ted_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_action      (o_action),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y)
    );

endmodule
